// File: rtl/core/segi_pkg.sv
package segi_pkg;

	// Default coordinate width: signed Q12.4 pixel coordinates.
	localparam int COORD_WIDTH = 16;

	// Control flags that travel alongside each beat through the pipeline.
	typedef struct packed {
		logic valid;
		logic hit;
		logic neg_x;
		logic neg_y;
	} segi_tag_t;

endpackage

// File: rtl/core/segi_front.sv
module segi_front #(
	parameter int W = segi_pkg::COORD_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [W-1:0]      a_start_x,
	input  logic signed [W-1:0]      a_start_y,
	input  logic signed [W-1:0]      a_end_x,
	input  logic signed [W-1:0]      a_end_y,
	input  logic signed [W-1:0]      b_start_x,
	input  logic signed [W-1:0]      b_start_y,
	input  logic signed [W-1:0]      b_end_x,
	input  logic signed [W-1:0]      b_end_y,
	output segi_pkg::segi_tag_t      tag,
	output logic [W-1:0]             x1,
	output logic [W-1:0]             y1,
	output logic [2*W+2:0]           den_mag,
	output logic [3*W+2:0]           num_x_mag,
	output logic [3*W+2:0]           num_y_mag
);

	localparam int DW = W + 1;
	localparam int PW = 2 * W + 2;
	localparam int P  = 2 * W + 3;
	localparam int SW = P + W + 1;

	// Stage 1: coordinate differences.
	logic                 v_s1;
	logic signed [W-1:0]  x1_s1, y1_s1;
	logic signed [DW-1:0] dx12_s1, dy12_s1, dx34_s1, dy34_s1;
	logic signed [DW-1:0] dx13_s1, dy13_s1, dx21_s1, dy21_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x1_s1   <= a_start_x;
		y1_s1   <= a_start_y;
		dx12_s1 <= DW'(a_start_x) - DW'(a_end_x);
		dy12_s1 <= DW'(a_start_y) - DW'(a_end_y);
		dx34_s1 <= DW'(b_start_x) - DW'(b_end_x);
		dy34_s1 <= DW'(b_start_y) - DW'(b_end_y);
		dx13_s1 <= DW'(a_start_x) - DW'(b_start_x);
		dy13_s1 <= DW'(a_start_y) - DW'(b_start_y);
		dx21_s1 <= DW'(a_end_x) - DW'(a_start_x);
		dy21_s1 <= DW'(a_end_y) - DW'(a_start_y);
	end

	// Stage 2: the six cross products.
	logic                 v_s2;
	logic signed [W-1:0]  x1_s2, y1_s2;
	logic signed [DW-1:0] dx21_s2, dy21_s2;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x1_s2   <= x1_s1;
		y1_s2   <= y1_s1;
		dx21_s2 <= dx21_s1;
		dy21_s2 <= dy21_s1;
		pa_s2   <= dx12_s1 * dy34_s1;
		pb_s2   <= dy12_s1 * dx34_s1;
		pc_s2   <= dx13_s1 * dy34_s1;
		pd_s2   <= dy13_s1 * dx34_s1;
		pe_s2   <= dx12_s1 * dy13_s1;
		pf_s2   <= dy12_s1 * dx13_s1;
	end

	// Stage 3: denominator and the two parameter numerators.
	logic                 v_s3;
	logic signed [W-1:0]  x1_s3, y1_s3;
	logic signed [DW-1:0] dx21_s3, dy21_s3;
	logic signed [P-1:0]  den_s3, tn_s3, un_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x1_s3   <= x1_s2;
		y1_s3   <= y1_s2;
		dx21_s3 <= dx21_s2;
		dy21_s3 <= dy21_s2;
		den_s3  <= P'(pa_s2) - P'(pb_s2);
		tn_s3   <= P'(pc_s2) - P'(pd_s2);
		un_s3   <= P'(pf_s2) - P'(pe_s2);
	end

	// Range test of t and u by sign and magnitude, without dividing.
	logic [P-1:0] den_abs, tn_abs, un_abs;
	logic         t_ok, u_ok, hit_c;

	always_comb begin
		den_abs = den_s3[P-1] ? P'(-den_s3) : P'(den_s3);
		tn_abs  = tn_s3[P-1]  ? P'(-tn_s3)  : P'(tn_s3);
		un_abs  = un_s3[P-1]  ? P'(-un_s3)  : P'(un_s3);
		t_ok    = (tn_s3 == '0) ||
			((tn_s3[P-1] == den_s3[P-1]) && (tn_abs <= den_abs));
		u_ok    = (un_s3 == '0) ||
			((un_s3[P-1] == den_s3[P-1]) && (un_abs <= den_abs));
		hit_c   = (den_s3 != '0) && t_ok && u_ok;
	end

	// Stage 4: hit flag and the scaled numerators tn*(x2-x1), tn*(y2-y1).
	logic                 v_s4, hit_s4;
	logic signed [W-1:0]  x1_s4, y1_s4;
	logic signed [P-1:0]  den_s4;
	logic signed [SW-1:0] sx_s4, sy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4 <= hit_c;
		x1_s4  <= x1_s3;
		y1_s4  <= y1_s3;
		den_s4 <= den_s3;
		sx_s4  <= tn_s3 * dx21_s3;
		sy_s4  <= tn_s3 * dy21_s3;
	end

	// Stage 5: magnitudes and quotient signs for the divider chain.
	logic [SW-1:0] sx_abs, sy_abs;
	logic [P-1:0]  d_abs;

	always_comb begin
		sx_abs = sx_s4[SW-1] ? SW'(-sx_s4) : SW'(sx_s4);
		sy_abs = sy_s4[SW-1] ? SW'(-sy_s4) : SW'(sy_s4);
		d_abs  = den_s4[P-1] ? P'(-den_s4) : P'(den_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag <= '0;
		end else begin
			tag.valid <= v_s4;
			tag.hit   <= hit_s4;
			tag.neg_x <= sx_s4[SW-1] ^ den_s4[P-1];
			tag.neg_y <= sy_s4[SW-1] ^ den_s4[P-1];
		end
	end

	always_ff @(posedge clk) begin
		x1        <= x1_s4;
		y1        <= y1_s4;
		den_mag   <= d_abs;
		num_x_mag <= sx_abs[P+W-1:0];
		num_y_mag <= sy_abs[P+W-1:0];
	end

endmodule

// File: rtl/core/segi_cell.sv
module segi_cell #(
	parameter int W = segi_pkg::COORD_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  segi_pkg::segi_tag_t tag_in,
	input  logic [W-1:0]        x1_in,
	input  logic [W-1:0]        y1_in,
	input  logic [2*W+2:0]      d_in,
	input  logic [2*W+2:0]      rem_x_in,
	input  logic [W-1:0]        lq_x_in,
	input  logic [2*W+2:0]      rem_y_in,
	input  logic [W-1:0]        lq_y_in,
	output segi_pkg::segi_tag_t tag_q,
	output logic [W-1:0]        x1_q,
	output logic [W-1:0]        y1_q,
	output logic [2*W+2:0]      d_q,
	output logic [2*W+2:0]      rem_x_q,
	output logic [W-1:0]        lq_x_q,
	output logic [2*W+2:0]      rem_y_q,
	output logic [W-1:0]        lq_y_q
);

	localparam int P = 2 * W + 3;

	// One restoring step per lane: shift in the next dividend bit, try to subtract.
	logic [P:0]   sh_x, sh_y, dif_x, dif_y;
	logic         qb_x, qb_y;
	logic [P-1:0] rem_x_d, rem_y_d;

	always_comb begin
		sh_x    = {rem_x_in, lq_x_in[W-1]};
		sh_y    = {rem_y_in, lq_y_in[W-1]};
		dif_x   = sh_x - {1'b0, d_in};
		dif_y   = sh_y - {1'b0, d_in};
		qb_x    = (sh_x >= {1'b0, d_in});
		qb_y    = (sh_y >= {1'b0, d_in});
		rem_x_d = qb_x ? dif_x[P-1:0] : sh_x[P-1:0];
		rem_y_d = qb_y ? dif_y[P-1:0] : sh_y[P-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_in;
		end
	end

	// The quotient bits enter at the bottom as the dividend bits leave the top.
	always_ff @(posedge clk) begin
		x1_q    <= x1_in;
		y1_q    <= y1_in;
		d_q     <= d_in;
		rem_x_q <= rem_x_d;
		rem_y_q <= rem_y_d;
		lq_x_q  <= {lq_x_in[W-2:0], qb_x};
		lq_y_q  <= {lq_y_in[W-2:0], qb_y};
	end

endmodule

// File: rtl/core/segment_intersection.sv
// From the accepting edge to the edge that takes the result, a beat passes five arithmetic
// stages, one divider cell per quotient bit, and the output register. Throughput: one beat
// per cycle; busy is never raised.
// The quotient is produced one bit per cell along a chain of COORD_WIDTH cells.
// Reset clears all valid flags and the result strobe; no beat in flight survives it.
// The receiver cannot stall: done is high for exactly one cycle per result.
module segment_intersection #(
	parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] a_start_x,
	input  logic signed [COORD_WIDTH-1:0] a_start_y,
	input  logic signed [COORD_WIDTH-1:0] a_end_x,
	input  logic signed [COORD_WIDTH-1:0] a_end_y,
	input  logic signed [COORD_WIDTH-1:0] b_start_x,
	input  logic signed [COORD_WIDTH-1:0] b_start_y,
	input  logic signed [COORD_WIDTH-1:0] b_end_x,
	input  logic signed [COORD_WIDTH-1:0] b_end_y,
	output logic                          done,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] hit_x,
	output logic signed [COORD_WIDTH-1:0] hit_y
);

	localparam int W   = COORD_WIDTH;
	localparam int P   = 2 * W + 3;
	localparam int LAT = W + 6;

	// The pipeline never holds off a new beat.
	assign busy = 1'b0;

	// Signals between the cells of the divider chain; index zero is the front end.
	segi_pkg::segi_tag_t tag_c   [W+1];
	logic [W-1:0]        x1_c    [W+1];
	logic [W-1:0]        y1_c    [W+1];
	logic [P-1:0]        d_c     [W+1];
	logic [P-1:0]        rem_x_c [W+1];
	logic [W-1:0]        lq_x_c  [W+1];
	logic [P-1:0]        rem_y_c [W+1];
	logic [W-1:0]        lq_y_c  [W+1];
	logic [P+W-1:0]      nx_mag, ny_mag;

	segi_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.tag       (tag_c[0]),
		.x1        (x1_c[0]),
		.y1        (y1_c[0]),
		.den_mag   (d_c[0]),
		.num_x_mag (nx_mag),
		.num_y_mag (ny_mag)
	);

	// The quotient fits in W bits, so the upper dividend part starts below the divisor.
	assign rem_x_c[0] = nx_mag[P+W-1:W];
	assign lq_x_c[0]  = nx_mag[W-1:0];
	assign rem_y_c[0] = ny_mag[P+W-1:W];
	assign lq_y_c[0]  = ny_mag[W-1:0];

	// Divider chain: each cell settles one quotient bit for both coordinates.
	for (genvar k = 0; k < W; k++) begin : g_cell
		segi_cell #(.W(W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tag_in   (tag_c[k]),
			.x1_in    (x1_c[k]),
			.y1_in    (y1_c[k]),
			.d_in     (d_c[k]),
			.rem_x_in (rem_x_c[k]),
			.lq_x_in  (lq_x_c[k]),
			.rem_y_in (rem_y_c[k]),
			.lq_y_in  (lq_y_c[k]),
			.tag_q    (tag_c[k+1]),
			.x1_q     (x1_c[k+1]),
			.y1_q     (y1_c[k+1]),
			.d_q      (d_c[k+1]),
			.rem_x_q  (rem_x_c[k+1]),
			.lq_x_q   (lq_x_c[k+1]),
			.rem_y_q  (rem_y_c[k+1]),
			.lq_y_q   (lq_y_c[k+1])
		);
	end

	// Apply the quotient sign and add the first endpoint; a miss gives a zero point.
	segi_pkg::segi_tag_t tag_end;
	logic [W-1:0]        qx_s, qy_s, px, py;

	always_comb begin
		tag_end = tag_c[W];
		qx_s    = tag_end.neg_x ? W'(-lq_x_c[W]) : lq_x_c[W];
		qy_s    = tag_end.neg_y ? W'(-lq_y_c[W]) : lq_y_c[W];
		px      = tag_end.hit ? W'(x1_c[W] + qx_s) : '0;
		py      = tag_end.hit ? W'(y1_c[W] + qy_s) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit   <= tag_end.hit;
		hit_x <= px;
		hit_y <= py;
	end

	// Every accepted beat comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat did not produce a result after the pipeline latency");

	// The divider chain neither drops nor invents beats.
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		tag_c[0].valid |-> ##W tag_c[W].valid)
		else $error("beat lost in the divider chain");

	// A miss always reports the zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (hit_x == '0 && hit_y == '0))
		else $error("miss reported with a nonzero point");

	// The strobe only follows a beat leaving the chain.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(tag_c[W].valid))
		else $error("result strobe without a beat from the chain");

endmodule
